// ----- rtl/gscl_pkg.sv -----
// Package for the gradient stop color lookup block.
// Holds the field widths, function codes, table entry type and divider status type.
// No dependencies.
package gscl_pkg;

  // Field widths of the stream items.
  localparam int POS_W    = 8;
  localparam int COLOR_W  = 32;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 4;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 32;

  // Query percent clamp limits.
  localparam logic signed [POS_W-1:0] PCT_MIN = 8'sd0;
  localparam logic signed [POS_W-1:0] PCT_MAX = 8'sd100;

  // Function codes carried on s_tuser.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Channel blend arithmetic: (y - x) * n is 9 x 9 bits signed, its magnitude fits 16 bits.
  localparam int PROD_W  = 18;
  localparam int QUO_W   = 16;
  localparam int DIVS_W  = 8;
  localparam int STEP_W  = 5;
  localparam logic [STEP_W-1:0] DIV_STEPS = 5'd16;

  // One stored color stop.
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic [COLOR_W-1:0]      color;
  } entry_t;

  // Status returned by the serial divider.
  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_status_t;

endpackage

// ----- rtl/gscl_div.sv -----
// Restoring serial divider, one quotient bit per cycle, for the channel blend.
// Divides a 16-bit magnitude by an 8-bit nonzero divisor.
// Depends on gscl_pkg.
module gscl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gscl_pkg::QUO_W-1:0]  dividend,
  input  logic [gscl_pkg::DIVS_W-1:0] divisor,
  output logic [gscl_pkg::QUO_W-1:0]  quotient,
  output gscl_pkg::div_status_t       status
);
  import gscl_pkg::*;

  logic [DIVS_W-1:0] rem;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] steps;
  logic              done;
  logic [DIVS_W:0]   trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and test it.
  assign trial = {rem, quo[QUO_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= DIV_STEPS;
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (steps != '0) begin
      if (fits) begin
        rem <= DIVS_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DIVS_W-1:0];
      end
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

  assign quotient      = quo;
  assign status.done   = done;
  assign status.rem_nz = (rem != '0);

endmodule

// ----- rtl/gscl_table.sv -----
// Stop table memory: one write port and one read port with registered read data.
// Each word holds a signed stop position and its packed color.
// Depends on gscl_pkg.
module gscl_table #(
  parameter int MAX_STOPS = 8
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_STOPS)-1:0] wr_addr,
  input  gscl_pkg::entry_t             wr_data,
  input  logic [$clog2(MAX_STOPS)-1:0] rd_addr,
  output gscl_pkg::entry_t             rd_data
);
  import gscl_pkg::*;

  entry_t mem [MAX_STOPS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/gradient_stop_color_lookup.sv -----
// Gradient stop color lookup: sorted stop table with per-channel rational blending.
// An add moves each larger stop up one slot, a read and then a write per stop, and then
// writes the new stop; an add is dropped when the table is full.
// A query runs a stop scan, then four channels that each use the shared serial divider. One
// item is worked at a time; the result register lets the next item enter while a result
// waits. Synchronous reset empties the table; no clearing pass.
module gradient_stop_color_lookup #(
  parameter int MAX_STOPS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [gscl_pkg::S_DATA_W-1:0] s_tdata,  // position[7:0], stop_color[39:8]
  input  logic                          s_tuser,  // func
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gscl_pkg::M_DATA_W-1:0] m_tdata,  // color_out[31:0]
  output logic                          m_tuser   // table_full
);
  import gscl_pkg::*;

  localparam int IDX_W = $clog2(MAX_STOPS);
  localparam int CNT_W = $clog2(MAX_STOPS + 1);

  typedef enum logic [3:0] {
    IDLE, INS_RD, INS_CHK, INS_PUT, Q_LAST_RD, Q_LAST_CHK, Q_FIRST_CHK,
    Q_SCAN, Q_MUL, Q_DIV, Q_WAIT, OUT
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        k;
  logic [IDX_W-1:0]        addr;
  logic signed [POS_W-1:0] pos_in;
  logic [COLOR_W-1:0]      col_in;
  logic signed [POS_W-1:0] p;
  entry_t                  last_e;
  entry_t                  prev_e;
  logic [COLOR_W-1:0]      ca;
  logic [COLOR_W-1:0]      cb;
  logic [POS_W-1:0]        n;
  logic [POS_W-1:0]        m;
  logic [1:0]              ch;
  logic signed [PROD_W-1:0] prod;
  logic [COLOR_W-1:0]      res_color;
  logic                    res_full;

  entry_t                  rd_data;
  entry_t                  wr_data;
  logic                    wr_en;
  logic                    shift_up;
  logic signed [POS_W-1:0] rd_pos;
  logic signed [POS_W-1:0] s_pos;
  logic signed [POS_W-1:0] s_pct;
  logic signed [POS_W:0]   n_calc;
  logic signed [POS_W:0]   m_calc;
  logic [CH_W-1:0]         x_ch;
  logic [CH_W-1:0]         y_ch;
  logic signed [CH_W:0]    diff;
  logic signed [PROD_W-1:0] prod_calc;
  logic signed [PROD_W-1:0] prod_abs;
  logic [QUO_W-1:0]        quotient;
  div_status_t             div_st;
  logic                    div_start;
  logic signed [CH_W+1:0]  q_signed;
  logic signed [CH_W+2:0]  v_calc;
  logic [CH_W-1:0]         v_clamped;

  // Input field unpacking and percent clamp.
  assign s_pos = s_tdata[POS_W-1:0];
  assign s_pct = (s_pos < PCT_MIN) ? PCT_MIN : ((s_pos > PCT_MAX) ? PCT_MAX : s_pos);
  assign rd_pos = rd_data.pos;

  // Insertion moves the read entry up one slot while it lies above the new position.
  assign shift_up = (rd_pos > pos_in);
  assign wr_en    = ((state == INS_CHK) && shift_up) || (state == INS_PUT);
  assign wr_data  = (state == INS_PUT) ? entry_t'{pos: pos_in, color: col_in} : rd_data;

  gscl_table #(
    .MAX_STOPS (MAX_STOPS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (k),
    .wr_data (wr_data),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // Offsets of the query point and upper stop from the lower stop of the bracketing pair.
  assign n_calc = $signed({p[POS_W-1], p}) - $signed({prev_e.pos[POS_W-1], prev_e.pos});
  assign m_calc = $signed({rd_pos[POS_W-1], rd_pos})
                - $signed({prev_e.pos[POS_W-1], prev_e.pos});

  // Channel product (y - x) * n and its magnitude for the divider.
  assign x_ch      = ca[ch*CH_W +: CH_W];
  assign y_ch      = cb[ch*CH_W +: CH_W];
  assign diff      = $signed({1'b0, y_ch}) - $signed({1'b0, x_ch});
  assign prod_calc = diff * $signed({1'b0, n});
  assign prod_abs  = prod[PROD_W-1] ? -prod : prod;
  assign div_start = (state == Q_DIV);

  gscl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_abs[QUO_W-1:0]),
    .divisor  (m),
    .quotient (quotient),
    .status   (div_st)
  );

  // Floor of the signed quotient, added to the lower channel value and clamped to a byte.
  always_comb begin
    if (prod[PROD_W-1]) begin
      q_signed = -$signed({1'b0, quotient[CH_W:0]}) - $signed({9'd0, div_st.rem_nz});
    end else begin
      q_signed = $signed({1'b0, quotient[CH_W:0]});
    end
    v_calc = $signed({3'b000, x_ch}) + q_signed;
    if (v_calc < 0) begin
      v_clamped = '0;
    end else if (v_calc > $signed(11'd255)) begin
      v_clamped = '1;
    end else begin
      v_clamped = v_calc[CH_W-1:0];
    end
  end

  assign s_tready = (state == IDLE);

  // Sequencer, table bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            pos_in    <= s_pos;
            col_in    <= s_tdata[S_DATA_W-1:POS_W];
            p         <= s_pct;
            res_color <= '0;
            res_full  <= 1'b0;
            if (s_tuser == FUNC_ADD) begin
              if (count == CNT_W'(MAX_STOPS)) begin
                res_full <= 1'b1;
                state    <= OUT;
              end else if (count == '0) begin
                k     <= '0;
                state <= INS_PUT;
              end else begin
                k     <= IDX_W'(count);
                addr  <= IDX_W'(count - 1'b1);
                state <= INS_RD;
              end
            end else begin
              if (count == '0) begin
                state <= OUT;
              end else begin
                addr  <= IDX_W'(count - 1'b1);
                state <= Q_LAST_RD;
              end
            end
          end
        end
        INS_RD: begin
          state <= INS_CHK;
        end
        INS_CHK: begin
          if (shift_up) begin
            k <= k - 1'b1;
            if (k == IDX_W'(1)) begin
              state <= INS_PUT;
            end else begin
              addr  <= k - IDX_W'(2);
              state <= INS_RD;
            end
          end else begin
            state <= INS_PUT;
          end
        end
        INS_PUT: begin
          count <= count + 1'b1;
          state <= OUT;
        end
        Q_LAST_RD: begin
          addr  <= '0;
          state <= Q_LAST_CHK;
        end
        Q_LAST_CHK: begin
          last_e <= rd_data;
          addr   <= IDX_W'(1);
          state  <= Q_FIRST_CHK;
        end
        Q_FIRST_CHK: begin
          prev_e <= rd_data;
          addr   <= IDX_W'(2);
          if (p <= rd_pos) begin
            res_color <= rd_data.color;
            state     <= OUT;
          end else if (p >= last_e.pos) begin
            res_color <= last_e.color;
            state     <= OUT;
          end else begin
            state <= Q_SCAN;
          end
        end
        Q_SCAN: begin
          // The first stop at or above the point closes the bracketing pair.
          if (rd_pos >= p) begin
            ca    <= prev_e.color;
            cb    <= rd_data.color;
            n     <= n_calc[POS_W-1:0];
            m     <= m_calc[POS_W-1:0];
            ch    <= '0;
            state <= Q_MUL;
          end else begin
            prev_e <= rd_data;
            addr   <= addr + 1'b1;
          end
        end
        Q_MUL: begin
          prod  <= prod_calc;
          state <= Q_DIV;
        end
        Q_DIV: begin
          state <= Q_WAIT;
        end
        Q_WAIT: begin
          if (div_st.done) begin
            res_color[ch*CH_W +: CH_W] <= v_clamped;
            ch <= ch + 1'b1;
            if (ch == 2'(NUM_CH - 1)) begin
              state <= OUT;
            end else begin
              state <= Q_MUL;
            end
          end
        end
        OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_color;
            m_tuser  <= res_full;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/gradient_lookup_checker.sv -----
// Checker for the gradient stop color lookup block: watches both stream channels,
// keeps its own copy of the stop table, predicts every result and compares it.
// Depends on gscl_pkg for field widths, function codes and the table entry type.
module gradient_lookup_checker #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [gscl_pkg::S_DATA_W-1:0] s_tdata,  // position[7:0], stop_color[39:8]
  input  logic                          s_tuser,  // func
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [gscl_pkg::M_DATA_W-1:0] m_tdata,  // color_out[31:0]
  input  logic                          m_tuser,  // table_full
  output int                            mismatches,
  output int                            outstanding
);
  import gscl_pkg::*;

  // One predicted result transaction.
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               full;
  } lookup_result_t;

  entry_t         stops [TABLE_DEPTH];
  int             stop_total;
  lookup_result_t expected_results [$];

  // One channel between two stops, floored toward minus infinity.
  function automatic logic [CH_W-1:0] mix_channel(input int x, input int y, input int n,
                                                  input int m);
    int prod;
    int quo;
    int v;
    prod = (y - x) * n;
    quo  = prod / m;
    if ((prod % m) != 0 && prod < 0) quo = quo - 1;
    v = x + quo;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CH_W-1:0];
  endfunction

  // All four channels; a zero-width span keeps the lower stop's color.
  function automatic logic [COLOR_W-1:0] mix_color(input logic [COLOR_W-1:0] lo,
                                                   input logic [COLOR_W-1:0] hi,
                                                   input int n, input int m);
    logic [COLOR_W-1:0] res;
    if (m <= 0) return lo;
    res = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      res[ch*CH_W +: CH_W] = mix_channel(int'(lo[ch*CH_W +: CH_W]),
                                         int'(hi[ch*CH_W +: CH_W]), n, m);
    end
    return res;
  endfunction

  // Color at a query percent, clamped to the valid range first.
  function automatic logic [COLOR_W-1:0] predict_color(input logic signed [POS_W-1:0] pct_in);
    int p;
    int a;
    int b;
    int last;
    if (stop_total == 0) return '0;
    last = stop_total - 1;
    p = int'(pct_in);
    if (p < int'(PCT_MIN)) p = int'(PCT_MIN);
    if (p > int'(PCT_MAX)) p = int'(PCT_MAX);
    if (p <= int'($signed(stops[0].pos))) return stops[0].color;
    if (p >= int'($signed(stops[last].pos))) return stops[last].color;
    for (int i = 0; i < last; i++) begin
      a = int'($signed(stops[i].pos));
      b = int'($signed(stops[i+1].pos));
      if (p >= a && p <= b) return mix_color(stops[i].color, stops[i+1].color, p - a, b - a);
    end
    return stops[last].color;
  endfunction

  // Sorted insert after any stop at an equal position; returns 0 when the table is full.
  function automatic logic insert_stop(input logic signed [POS_W-1:0] pos,
                                       input logic [COLOR_W-1:0] color);
    int k;
    if (stop_total >= TABLE_DEPTH) return 1'b0;
    k = stop_total;
    while (k > 0 && $signed(stops[k-1].pos) > pos) begin
      stops[k] = stops[k-1];
      k--;
    end
    stops[k].pos   = pos;
    stops[k].color = color;
    stop_total++;
    return 1'b1;
  endfunction

  // Predict on each input transaction, compare on each output transaction.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      stop_total = 0;
      mismatches = 0;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_QUERY) begin
          want.color = predict_color($signed(s_tdata[POS_W-1:0]));
          want.full  = 1'b0;
        end else begin
          want.color = '0;
          want.full  = !insert_stop($signed(s_tdata[POS_W-1:0]),
                                    s_tdata[POS_W +: COLOR_W]);
        end
        expected_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got color_out %08h table_full %0b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.color) begin
            mismatches++;
            $display("%0t: color_out mismatch, expected %08h, got %08h",
                     $time, want.color, m_tdata);
          end
          if (m_tuser !== want.full) begin
            mismatches++;
            $display("%0t: table_full mismatch, expected %0b, got %0b",
                     $time, want.full, m_tuser);
          end
        end
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Top of the gradient stop color lookup testbench: clock, reset, stimulus and verdict.
// Depends on gscl_pkg, the gradient_stop_color_lookup block and gradient_lookup_checker.
module tb_top;
  import gscl_pkg::*;

  localparam int TABLE_DEPTH  = 8;
  localparam int RANDOM_ITEMS = 1832;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 4 * (TABLE_DEPTH + 80);

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                s_tuser  = FUNC_ADD;
  logic                m_tready = 1'b0;
  logic                s_tready;
  logic                m_tvalid;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;

  int mismatches;
  int outstanding;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int cycle_count  = 0;
  int lookups_sent = 0;
  int inserts_sent = 0;
  int gap_by_phase   [4] = '{0, 56, 0, 37};
  int stall_by_phase [4] = '{0, 0, 56, 37};

  gradient_stop_color_lookup #(
    .MAX_STOPS(TABLE_DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  gradient_lookup_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Clock with a period of 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Present one transaction after random idle cycles and hold it until accepted.
  task automatic send_item(input logic func, input logic signed [POS_W-1:0] pos,
                           input logic [COLOR_W-1:0] color);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {color, pos};
    do @(posedge clk); while (!s_tready);
    if (func == FUNC_QUERY) lookups_sent++;
    else inserts_sent++;
  endtask

  task automatic lookup_at(input logic signed [POS_W-1:0] pos);
    send_item(FUNC_QUERY, pos, $urandom());
  endtask

  task automatic add_stop(input logic signed [POS_W-1:0] pos, input logic [COLOR_W-1:0] color);
    send_item(FUNC_ADD, pos, color);
  endtask

  // Hold the sender off until every outstanding result has been returned.
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly in-range lookups; inserts are rare until the table fills, then dropped ones recur.
  task automatic random_item();
    int                      roll;
    int                      v;
    logic signed [POS_W-1:0] pos;
    logic [COLOR_W-1:0]      color;
    roll  = $urandom_range(999);
    color = $urandom();
    if ($urandom_range(7) == 0) color = $urandom_range(1) ? '1 : '0;
    if ((inserts_sent < TABLE_DEPTH && roll < 7) || (inserts_sent >= TABLE_DEPTH && roll < 40))
    begin
      if ($urandom_range(3) == 0) begin
        pos = POS_W'($urandom());
      end else begin
        v   = int'($urandom_range(120)) - 10;
        pos = v[POS_W-1:0];
      end
      add_stop(pos, color);
    end else begin
      case ($urandom_range(9))
        0: pos = POS_W'($urandom());
        1: begin
          case ($urandom_range(5))
            0: pos = -8'sd128;
            1: pos = 8'sd127;
            2: pos = PCT_MIN;
            3: pos = PCT_MAX;
            4: pos = -8'sd1;
            default: pos = 8'sd101;
          endcase
        end
        default: begin
          v   = int'($urandom_range(100));
          pos = v[POS_W-1:0];
        end
      endcase
      send_item(FUNC_QUERY, pos, color);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int dropped;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lookups on an empty table, at both field extremes.
    lookup_at(-8'sd128);
    lookup_at(8'sd127);
    // A single stop: below, at and above it.
    add_stop(8'sd30, 32'h1020_3040);
    lookup_at(8'sd0);
    lookup_at(8'sd30);
    lookup_at(8'sd100);
    // A second stop at the same position lands after the first.
    add_stop(8'sd30, 32'hF0E0_D0C0);
    lookup_at(8'sd30);
    lookup_at(8'sd31);
    // A real span, from just above its start up to its end.
    add_stop(8'sd70, 32'h00FF_7F80);
    lookup_at(8'sd31);
    lookup_at(8'sd50);
    lookup_at(8'sd69);
    lookup_at(8'sd70);
    // Stops outside the percent range are kept as given.
    add_stop(8'sd127, 32'hFFFF_FFFF);
    lookup_at(8'sd100);
    add_stop(-8'sd128, 32'h0000_0000);
    lookup_at(-8'sd128);
    lookup_at(8'sd127);
    lookup_at(8'sd1);
    wait_for_drain();

    // Random part over the four pacing phases, drained between phases.
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = gap_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) random_item();
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    dropped = (inserts_sent > TABLE_DEPTH) ? inserts_sent - TABLE_DEPTH : 0;
    $display("Sent %0d lookups and %0d stop inserts, %0d of them against a full table,",
             lookups_sent, inserts_sent, dropped);
    $display("under free-running, sender-gapped, receiver-stalled and mixed pacing.");
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- gradient_stop_color_lookup.f -----
rtl/gscl_pkg.sv
rtl/gscl_div.sv
rtl/gscl_table.sv
rtl/gradient_stop_color_lookup.sv
sim/gradient_lookup_checker.sv
sim/tb_top.sv
